/* rtl/bm3x3_pkg.sv */
// ----------------------------------------------------------------------------
// bm3x3_pkg
// Shared types and codes for the 3x3 binary morphology core.
// ----------------------------------------------------------------------------
package bm3x3_pkg;

  localparam logic [7:0] PIX_OBJ = 8'h00;
  localparam logic [7:0] PIX_BG  = 8'hFF;

  localparam logic [2:0] MODE_DILATE   = 3'd0;
  localparam logic [2:0] MODE_ERODE    = 3'd1;
  localparam logic [2:0] MODE_OPEN     = 3'd2;
  localparam logic [2:0] MODE_CLOSE    = 3'd3;
  localparam logic [2:0] MODE_BOUNDARY = 3'd4;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_MASK   = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [8:0] MASK_FULL = 9'h1FF;

  typedef enum logic [1:0] {
    OP_DILATE,
    OP_ERODE,
    OP_BOUNDARY
  } op_t;

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop_only;
  } stage_cmd_t;

  typedef struct packed {
    logic full;
    logic pend;
  } stage_stat_t;

  typedef struct packed {
    logic       popped;
    logic [7:0] pix;
    logic       last;
  } stage_res_t;

endpackage

/* rtl/binary_morphology_3x3_core.sv */
// ----------------------------------------------------------------------------
// binary_morphology_3x3_core
// Streaming 3x3 dilate, erode, open, close and boundary on byte pixels.
//
//   Port group | Direction | Contents
//   in_        | input     | in_item_t: pixel_in, flush
//   out_       | output    | out_item_t: pixel_out, frame_end
//   cfg_       | input     | mode, struct_mask, image_width, image_height
//
// One item is taken per clock while the input is not stalled; its result, if any,
// is in the output register in the next cycle; both stages evaluate it combinationally.
// Results lag by W+1 items, or 2W+2 in open and close mode.
// Reset is synchronous and clears the counters; line stores need no clearing.
// The input stalls only while a result waits in the output register.
// ----------------------------------------------------------------------------
module binary_morphology_3x3_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  bm3x3_pkg::in_item_t   in_item,
  output logic                  in_stall,
  output logic                  out_valid,
  output bm3x3_pkg::out_item_t  out_item,
  input  logic                  out_stall,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [10:0]           cfg_wr_data
);

  localparam int CW = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int W0 = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int H0 = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  logic [2:0]    mode_r;
  logic [8:0]    mask_r;
  logic [WW-1:0] width_r, w_new, w_sel;
  logic [HW-1:0] height_r, h_new, h_sel;
  logic [CW-1:0] n_r;
  logic [WW+HW-1:0] prod;
  logic [31:0]   data_ext;

  logic                    out_valid_r;
  bm3x3_pkg::out_item_t    out_item_r;

  logic                    acc, two, fl;
  bm3x3_pkg::op_t          op1, op2;
  logic [8:0]              mask1;
  bm3x3_pkg::stage_cmd_t   cmd1, cmd2;
  bm3x3_pkg::stage_stat_t  st1, st2;
  bm3x3_pkg::stage_res_t   rs1, rs2, rsl;

  assign data_ext = 32'(cfg_wr_data);

  always_comb begin
    if (data_ext == 32'd0) begin
      w_new = WW'(1);
      h_new = HW'(1);
    end else begin
      w_new = (data_ext > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(data_ext);
      h_new = (data_ext > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(data_ext);
    end
    w_sel = (cfg_index == bm3x3_pkg::REG_WIDTH) ? w_new : width_r;
    h_sel = (cfg_index == bm3x3_pkg::REG_HEIGHT) ? h_new : height_r;
  end

  assign prod = (WW+HW)'(w_sel) * (WW+HW)'(h_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bm3x3_pkg::MODE_DILATE;
      mask_r   <= bm3x3_pkg::MASK_FULL;
      width_r  <= WW'(W0);
      height_r <= HW'(H0);
      n_r      <= CW'(W0 * H0);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bm3x3_pkg::REG_MODE:   mode_r   <= cfg_wr_data[2:0];
        bm3x3_pkg::REG_MASK:   mask_r   <= cfg_wr_data[8:0];
        bm3x3_pkg::REG_WIDTH:  width_r  <= w_new;
        bm3x3_pkg::REG_HEIGHT: height_r <= h_new;
        default:               mode_r   <= mode_r;
      endcase
      n_r <= CW'(prod);
    end
  end

  always_comb begin
    two   = 1'b0;
    op1   = bm3x3_pkg::OP_DILATE;
    op2   = bm3x3_pkg::OP_DILATE;
    mask1 = mask_r;
    unique case (mode_r)
      bm3x3_pkg::MODE_ERODE: begin
        op1 = bm3x3_pkg::OP_ERODE;
      end
      bm3x3_pkg::MODE_OPEN: begin
        two = 1'b1;
        op1 = bm3x3_pkg::OP_ERODE;
        op2 = bm3x3_pkg::OP_DILATE;
      end
      bm3x3_pkg::MODE_CLOSE: begin
        two = 1'b1;
        op1 = bm3x3_pkg::OP_DILATE;
        op2 = bm3x3_pkg::OP_ERODE;
      end
      bm3x3_pkg::MODE_BOUNDARY: begin
        op1   = bm3x3_pkg::OP_BOUNDARY;
        mask1 = bm3x3_pkg::MASK_FULL;
      end
      default: begin
        op1 = bm3x3_pkg::OP_DILATE;
      end
    endcase
  end

  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;
  assign fl       = in_item.flush | st1.full | (two & st2.full);

  assign cmd1.push     = acc & ~fl;
  assign cmd1.pop_only = acc & fl & st1.pend;
  assign cmd2.push     = two & rs1.popped;
  assign cmd2.pop_only = acc & two & fl & ~st1.pend & st2.pend;

  bm3x3_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_stage1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr_en),
    .cmd        (cmd1),
    .pix        (in_item.pixel_in),
    .op         (op1),
    .mask       (mask1),
    .width      (width_r),
    .frame_size (n_r),
    .stat       (st1),
    .res        (rs1)
  );

  bm3x3_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_stage2 (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr_en),
    .cmd        (cmd2),
    .pix        (rs1.pix),
    .op         (op2),
    .mask       (mask_r),
    .width      (width_r),
    .frame_size (n_r),
    .stat       (st2),
    .res        (rs2)
  );

  assign rsl = two ? rs2 : rs1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsl.popped) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsl.popped) begin
      out_item_r.pixel_out <= rsl.pix;
      out_item_r.frame_end <= rsl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/bm3x3_stage.sv */
// ----------------------------------------------------------------------------
// bm3x3_stage
// One morphology stage: position counters, a three-way replicated line
// store and the 3x3 window evaluation for the pixel that is popped.
// ----------------------------------------------------------------------------
module bm3x3_stage #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      restart,
  input  bm3x3_pkg::stage_cmd_t                     cmd,
  input  logic [7:0]                                pix,
  input  bm3x3_pkg::op_t                            op,
  input  logic [8:0]                                mask,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]            width,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] frame_size,
  output bm3x3_pkg::stage_stat_t                    stat,
  output bm3x3_pkg::stage_res_t                     res
);

  localparam int CW    = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
  localparam int WW    = $clog2(MAX_WIDTH+1);
  localparam int DW    = $clog2(MAX_WIDTH+3);
  localparam int AW    = $clog2(2*MAX_WIDTH+4);
  localparam int DEPTH = 1 << AW;
  localparam int CLW   = $clog2(MAX_WIDTH);

  logic [CW-1:0]  taken_r, taken_nxt, given_r, given_nxt;
  logic [DW-1:0]  d_r, d_nxt;
  logic [CLW-1:0] gcol_r, gcol_nxt;
  logic           row_nz_r, row_nz_nxt;
  logic [7:0]     hist1_r, hist2_r, hist3_r;

  logic [7:0]     cur_r [3];
  logic [7:0]     up_r  [3];

  logic           popped, frame_done, col_wrap;
  logic [DW-1:0]  w_d, d_after;
  logic [7:0]     r1, r2, r3;
  logic           e0, e1, e2, left_ok, right_ok;
  logic [7:0]     nb [9];
  logic [8:0]     vld, emask;
  logic           hit_dil, hit_ero;
  logic [7:0]     center, eroded, result;
  logic [AW-1:0]  ga, wa;

  assign w_d     = DW'(width);
  assign popped  = cmd.pop_only | (cmd.push & (d_r == w_d + DW'(1)));
  assign d_after = cmd.push ? d_r + DW'(1) : d_r;

  assign r1 = cmd.push ? pix     : hist1_r;
  assign r2 = cmd.push ? hist1_r : hist2_r;
  assign r3 = cmd.push ? hist2_r : hist3_r;

  assign e0 = (d_after == w_d);
  assign e1 = (d_after == w_d + DW'(1));
  assign e2 = (d_after == w_d + DW'(2));

  assign left_ok  = (gcol_r != '0);
  assign right_ok = (WW'(gcol_r) + WW'(1) != width);

  always_comb begin
    nb[0] = up_r[0];
    nb[1] = up_r[1];
    nb[2] = up_r[2];
    nb[3] = cur_r[0];
    nb[4] = (d_r == DW'(1)) ? hist1_r : cur_r[1];
    nb[5] = (d_r == DW'(2)) ? hist1_r : cur_r[2];
    nb[6] = e0 ? r1 : (e1 ? r2 : r3);
    nb[7] = e1 ? r1 : r2;
    nb[8] = r1;
    vld[0] = row_nz_r & left_ok;
    vld[1] = row_nz_r;
    vld[2] = row_nz_r & right_ok;
    vld[3] = left_ok;
    vld[4] = 1'b1;
    vld[5] = right_ok & (d_after > DW'(1));
    vld[6] = left_ok & (e0 | e1 | e2);
    vld[7] = e1 | e2;
    vld[8] = right_ok & e2;
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      emask[i] = (op == bm3x3_pkg::OP_DILATE) ? mask[8-i] : mask[i];
    end
  end

  always_comb begin
    hit_dil = 1'b0;
    hit_ero = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (vld[i] && emask[i] && nb[i] == bm3x3_pkg::PIX_OBJ) begin
        hit_dil = 1'b1;
      end
      if (vld[i] && emask[i] && nb[i] == bm3x3_pkg::PIX_BG) begin
        hit_ero = 1'b1;
      end
    end
  end

  assign center = nb[4];
  assign eroded = (center == bm3x3_pkg::PIX_OBJ && hit_ero) ? bm3x3_pkg::PIX_BG : center;

  always_comb begin
    unique case (op)
      bm3x3_pkg::OP_DILATE:   result = hit_dil ? bm3x3_pkg::PIX_OBJ : bm3x3_pkg::PIX_BG;
      bm3x3_pkg::OP_ERODE:    result = eroded;
      bm3x3_pkg::OP_BOUNDARY: result = (eroded == bm3x3_pkg::PIX_OBJ) ? bm3x3_pkg::PIX_BG
                                                                      : center;
      default:                result = hit_dil ? bm3x3_pkg::PIX_OBJ : bm3x3_pkg::PIX_BG;
    endcase
  end

  assign frame_done = popped & ((given_r + CW'(1)) >= frame_size);
  assign col_wrap   = (WW'(gcol_r) + WW'(1) == width);

  always_comb begin
    taken_nxt  = taken_r;
    given_nxt  = given_r;
    d_nxt      = d_r;
    gcol_nxt   = gcol_r;
    row_nz_nxt = row_nz_r;
    if (restart || frame_done) begin
      taken_nxt  = '0;
      given_nxt  = '0;
      d_nxt      = '0;
      gcol_nxt   = '0;
      row_nz_nxt = 1'b0;
    end else begin
      if (cmd.push) begin
        taken_nxt = taken_r + CW'(1);
      end
      if (popped) begin
        given_nxt = given_r + CW'(1);
        if (col_wrap) begin
          gcol_nxt   = '0;
          row_nz_nxt = 1'b1;
        end else begin
          gcol_nxt = gcol_r + CLW'(1);
        end
      end
      d_nxt = d_after - DW'(popped);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r  <= '0;
      given_r  <= '0;
      d_r      <= '0;
      gcol_r   <= '0;
      row_nz_r <= 1'b0;
    end else begin
      taken_r  <= taken_nxt;
      given_r  <= given_nxt;
      d_r      <= d_nxt;
      gcol_r   <= gcol_nxt;
      row_nz_r <= row_nz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      hist1_r <= pix;
      hist2_r <= hist1_r;
      hist3_r <= hist2_r;
    end
  end

  assign ga = given_nxt[AW-1:0];
  assign wa = AW'(width);

  for (genvar k = 0; k < 3; k++) begin : g_copy
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (cmd.push) begin
        mem[taken_r[AW-1:0]] <= pix;
      end
      cur_r[k] <= mem[ga + AW'(k) - AW'(1)];
      up_r[k]  <= mem[ga - wa + AW'(k) - AW'(1)];
    end
  end

  assign stat.full  = (taken_r >= frame_size);
  assign stat.pend  = (d_r != '0);
  assign res.popped = popped;
  assign res.pix    = result;
  assign res.last   = frame_done;

endmodule
